FILE: rtl/core/bsg_pkg.sv
// Shared types, codes and constants of the six-axis Bresenham step generator.
package bsg_pkg;

	localparam int AXES_DEF   = 6;
	localparam int PIN_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	typedef enum logic [2:0] {
		MODE_TICK   = 3'd0,
		MODE_HEADER = 3'd1,
		MODE_RATE   = 3'd2,
		MODE_START  = 3'd3,
		MODE_READ   = 3'd4
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEP_INV = 2'd0,
		CFG_DIR_INV  = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0]       mode;
		logic [7:0]       block_tag;
		logic [31:0]      prog_line;
		logic [15:0]      segment_steps;
		logic [30:0]      event_count;
		logic [PIN_W-1:0] travel_dir;
		logic [15:0]      timer_delay;
		logic [7:0]       tick_presc;
		logic [2:0]       axis_index;
		logic [30:0]      axis_steps;
	} bsg_in_t;

	typedef struct packed {
		logic [PIN_W-1:0] step_out;
		logic [PIN_W-1:0] dir_bits;
		logic             active;
		logic             segment_done;
		logic             timer_load;
		logic [15:0]      new_timer_delay;
		logic [7:0]       new_tick_presc;
		logic [31:0]      exec_line;
		logic [31:0]      position;
	} bsg_out_t;

endpackage

FILE: rtl/core/bsg_stream_if.sv
// Valid/ready item channel with a typed payload.
interface bsg_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/bsg_cfg_if.sv
// Register write channel: valid/ready with register index and write data.
interface bsg_cfg_if
	import bsg_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/multi_axis_bresenham_step_generator.sv
// Multi-axis Bresenham step generator: command register, per-axis error units, result register.
// Throughput: one item per clock unless a stalled sink holds the result register; the
// per-axis add-compare-subtract units all run in parallel. An accepted item is worked on from
// its input register, and the result register holds its result (if any) while the sink stalls.
// Reset (arst_n low, asynchronous): all control, counters, positions, patterns and masks clear;
// the staged segment header and staged axis rates are not reset and are defined once written.
module multi_axis_bresenham_step_generator
	import bsg_pkg::*;
#(
	parameter int AXES = AXES_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	bsg_stream_if.sink   cmd,
	bsg_stream_if.source rsp,
	bsg_cfg_if.sink      cfg
);

	localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

	// configuration
	logic [PIN_W-1:0] step_inv_q, dir_inv_q;

	// input stage
	logic    s1_valid;
	bsg_in_t s1;

	// block state
	logic             running_q, seg_loaded_q, pend_loaded_q, block_known_q;
	logic [PIN_W-1:0] step_pat_q, dir_pat_q;
	logic [7:0]       cur_tag_q;
	logic [30:0]      cur_events_q;
	logic [PIN_W-1:0] cur_dir_q;
	logic [30:0]      cur_rate_q [AXES];
	logic [32:0]      err_q      [AXES];
	logic [31:0]      pos_q      [AXES];
	logic [15:0]      steps_left_q;
	logic [31:0]      line_q;

	// staged segment, no reset
	logic [7:0]       pend_tag_q;
	logic [31:0]      pend_line_q;
	logic [15:0]      pend_steps_q;
	logic [30:0]      pend_events_q;
	logic [PIN_W-1:0] pend_dir_q;
	logic [15:0]      pend_delay_q;
	logic [7:0]       pend_presc_q;
	logic [30:0]      pend_rate_q [AXES];

	// result register
	logic     out_valid_q;
	bsg_out_t out_q;

	// step logic
	mode_t            mode;
	logic             is_tick, is_read, has_result, out_free, s1_fire;
	logic             take, do_work, new_block;
	logic [30:0]      eff_events;
	logic [PIN_W-1:0] eff_dir;
	logic [30:0]      eff_rate   [AXES];
	logic [32:0]      err_next   [AXES];
	logic [31:0]      pos_next   [AXES];
	logic [PIN_W-1:0] new_steps;
	logic [15:0]      steps_base, steps_next;
	logic             seg_done;
	logic [31:0]      line_next;
	logic             idx_ok;
	bsg_out_t         res;

	assign mode       = mode_t'(s1.mode);
	assign is_tick    = (mode == MODE_TICK) && running_q;
	assign is_read    = (mode == MODE_READ);
	assign has_result = is_tick || is_read;
	assign out_free   = !out_valid_q || rsp.ready;
	assign s1_fire    = s1_valid && (!has_result || out_free);
	assign cmd.ready  = !s1_valid || s1_fire;

	assign take      = is_tick && !seg_loaded_q && pend_loaded_q;
	assign do_work   = is_tick && (seg_loaded_q || pend_loaded_q);
	assign new_block = take && (!block_known_q || (pend_tag_q != cur_tag_q));

	assign eff_events = new_block ? pend_events_q : cur_events_q;
	assign eff_dir    = new_block ? pend_dir_q : cur_dir_q;
	assign line_next  = new_block ? pend_line_q : line_q;
	assign idx_ok     = (s1.axis_index < 3'(AXES));

	always_comb begin
		logic [32:0] base;
		logic [32:0] sum;
		new_steps = '0;
		for (int i = 0; i < AXES; i++) begin
			eff_rate[i] = new_block ? pend_rate_q[i] : cur_rate_q[i];
			base        = new_block ? {3'b000, pend_events_q[30:1]} : err_q[i];
			sum         = base + {2'b00, eff_rate[i]};
			err_next[i] = sum;
			pos_next[i] = pos_q[i];
			if (sum > {2'b00, eff_events}) begin
				new_steps[i] = 1'b1;
				err_next[i]  = sum - {2'b00, eff_events};
				pos_next[i]  = eff_dir[i] ? pos_q[i] - 32'd1 : pos_q[i] + 32'd1;
			end
		end
	end

	assign steps_base = take ? pend_steps_q : steps_left_q;
	assign steps_next = (steps_base != 16'd0) ? steps_base - 16'd1 : 16'd0;
	assign seg_done   = (steps_next == 16'd0);

	always_comb begin
		res = '0;
		if (is_read) begin
			res.active    = running_q;
			res.exec_line = line_q;
			if (idx_ok) begin
				res.position = pos_q[s1.axis_index[AW-1:0]];
			end
		end else begin
			res.step_out  = step_pat_q;
			res.dir_bits  = dir_pat_q;
			res.exec_line = line_q;
			if (do_work) begin
				res.active       = 1'b1;
				res.segment_done = seg_done;
				res.exec_line    = line_next;
				if (take) begin
					res.timer_load      = 1'b1;
					res.new_timer_delay = pend_delay_q;
					res.new_tick_presc  = pend_presc_q;
				end
			end
		end
	end

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_inv_q <= '0;
			dir_inv_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				CFG_STEP_INV: step_inv_q <= cfg.data;
				CFG_DIR_INV:  dir_inv_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (cmd.ready) begin
			s1_valid <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			s1 <= cmd.payload;
		end
	end

	// staged segment
	always_ff @(posedge clk) begin
		if (s1_fire && (mode == MODE_HEADER)) begin
			pend_tag_q    <= s1.block_tag;
			pend_line_q   <= s1.prog_line;
			pend_steps_q  <= s1.segment_steps;
			pend_events_q <= s1.event_count;
			pend_dir_q    <= s1.travel_dir;
			pend_delay_q  <= s1.timer_delay;
			pend_presc_q  <= s1.tick_presc;
		end
		if (s1_fire && (mode == MODE_RATE) && idx_ok) begin
			pend_rate_q[s1.axis_index[AW-1:0]] <= s1.axis_steps;
		end
	end

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q     <= 1'b0;
			seg_loaded_q  <= 1'b0;
			pend_loaded_q <= 1'b0;
			block_known_q <= 1'b0;
			step_pat_q    <= '0;
			dir_pat_q     <= '0;
			cur_tag_q     <= '0;
			cur_events_q  <= '0;
			cur_dir_q     <= '0;
			steps_left_q  <= '0;
			line_q        <= '0;
			for (int i = 0; i < AXES; i++) begin
				cur_rate_q[i] <= '0;
				err_q[i]      <= '0;
				pos_q[i]      <= '0;
			end
		end else if (s1_fire) begin
			unique case (mode)
				MODE_HEADER: pend_loaded_q <= 1'b1;
				MODE_START: begin
					running_q  <= 1'b1;
					step_pat_q <= step_inv_q;
				end
				MODE_TICK: begin
					if (is_tick && !do_work) begin
						// buffer ran empty: stop
						running_q <= 1'b0;
					end
					if (do_work) begin
						if (take) begin
							pend_loaded_q <= 1'b0;
							dir_pat_q     <= eff_dir ^ dir_inv_q;
						end
						if (new_block) begin
							block_known_q <= 1'b1;
							cur_tag_q     <= pend_tag_q;
							cur_events_q  <= pend_events_q;
							cur_dir_q     <= pend_dir_q;
							line_q        <= pend_line_q;
						end
						for (int i = 0; i < AXES; i++) begin
							cur_rate_q[i] <= eff_rate[i];
							err_q[i]      <= err_next[i];
							pos_q[i]      <= pos_next[i];
						end
						steps_left_q <= steps_next;
						seg_loaded_q <= !seg_done;
						step_pat_q   <= new_steps ^ step_inv_q;
					end
				end
				MODE_RATE, MODE_READ: ;
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_fire && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_fire && has_result) begin
			out_q <= res;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	// a loaded segment only exists while interpolating
	assert property (@(posedge clk) disable iff (!arst_n) seg_loaded_q |-> running_q)
		else $error("segment loaded while not running");

	// the staged segment is consumed only by a tick that takes it
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(pend_loaded_q) |-> $past(s1_fire && take))
		else $error("staged segment dropped without being taken");

	// a result that loads the timer comes from an active tick
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.timer_load) |-> out_q.active)
		else $error("timer load on an inactive result");

	// a stalled input stage means a result is waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> (s1_valid && out_valid_q))
		else $error("input stalled without a waiting result");

endmodule
